### design/opatan_pkg.sv
`timescale 1ns / 1ps

package opatan_pkg;

    // default sizes
    localparam int OPERAND_WIDTH_DEF = 16;
    localparam int RATIO_FRAC_DEF    = 16;
    localparam int QUEUE_DEPTH       = 4;

    // result and accumulator widths
    localparam int ANGLE_WIDTH = 16;
    localparam int ACC_WIDTH   = 24;
    localparam int SUM_WIDTH   = 17;

    // cubic coefficients, centidegrees in q8
    localparam logic signed [ACC_WIDTH-1:0] COEF_1 = 24'sd1510919;
    localparam logic signed [ACC_WIDTH-1:0] COEF_2 = -24'sd261672;
    localparam logic signed [ACC_WIDTH-1:0] COEF_3 = -24'sd97247;

    localparam int RES_ROUND   = 128;
    localparam int RES_SHIFT   = 8;
    localparam int OCTANT_SPAN = 4500;
    localparam int HALF_TURN   = 18000;
    localparam int FULL_TURN   = 36000;

    typedef logic [2:0] t_oct;

    typedef struct packed {
        logic ratio_zero;
        t_oct oct;
    } t_class;

    function automatic logic signed [SUM_WIDTH-1:0] octant_base(input t_oct oct);
        return SUM_WIDTH'(int'(oct) * OCTANT_SPAN);
    endfunction

endpackage

### design/octant_polynomial_atan2_core.sv
`timescale 1ns / 1ps
// path: an accepted request goes through the reduction stages, the middle queue, the divider,
//   the polynomial stages and the result queue before it can be popped; one quotient bit per divider stage
// throughput: one request per cycle, front and back each stall only on their own queue
// reset: synchronous active low, clears pipeline valid bits and both queue pointers;
//   payload registers keep whatever they held, no clearing pass

module octant_polynomial_atan2_core #(
    parameter int OPERAND_WIDTH       = opatan_pkg::OPERAND_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = opatan_pkg::RATIO_FRAC_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    // request side
    input  logic                                       push,
    output logic                                       full,
    input  logic signed [OPERAND_WIDTH-1:0]            i_y_component,
    input  logic signed [OPERAND_WIDTH-1:0]            i_x_component,
    // result side
    output logic                                       empty,
    input  logic                                       pop,
    output logic signed [opatan_pkg::ANGLE_WIDTH-1:0]  o_angle
);

    localparam int VW = OPERAND_WIDTH + 2;
    localparam int CB = $bits(opatan_pkg::t_class);
    localparam int MW = CB + 2 * VW;

    // front: octant reduction, two stages, advances while the middle queue has room
    logic                 front_en, front_valid, accept;
    logic signed [VW-1:0] front_x, front_y;
    opatan_pkg::t_class   front_class;

    // middle queue between the reduction and the divider
    logic [MW-1:0]        mid_wdata, mid_rdata;
    logic                 mid_push, mid_pop, mid_empty, mid_full;
    logic signed [VW-1:0] mid_x, mid_y;
    opatan_pkg::t_class   mid_class;

    // back: divider and polynomial, advances while the result queue has room
    logic                              back_en, div_valid, poly_valid, out_push, out_full;
    logic [RATIO_FRACTION_BITS:0]      div_t;
    opatan_pkg::t_oct                  div_oct;
    logic [opatan_pkg::ANGLE_WIDTH-1:0] poly_angle, out_data;

    assign front_en = ~mid_full;
    assign full     = mid_full;
    assign accept   = push & ~full;

    opatan_front #(
        .OPERAND_WIDTH (OPERAND_WIDTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (front_en),
        .i_valid (accept),
        .i_y     (i_y_component),
        .i_x     (i_x_component),
        .o_valid (front_valid),
        .o_x     (front_x),
        .o_y     (front_y),
        .o_class (front_class)
    );

    // reduced request is {class, x, y}
    assign mid_push  = front_en & front_valid;
    assign mid_wdata = {front_class, front_x, front_y};

    opatan_fifo #(
        .WIDTH (MW),
        .DEPTH (opatan_pkg::QUEUE_DEPTH)
    ) u_mid_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (mid_push),
        .i_data  (mid_wdata),
        .i_pop   (mid_pop),
        .o_data  (mid_rdata),
        .o_empty (mid_empty),
        .o_full  (mid_full)
    );

    assign mid_class = opatan_pkg::t_class'(mid_rdata[MW-1 -: CB]);
    assign mid_x     = $signed(mid_rdata[2*VW-1 -: VW]);
    assign mid_y     = $signed(mid_rdata[VW-1:0]);

    // the whole back pipeline moves together; one free slot downstream is enough
    assign back_en = ~out_full;
    assign mid_pop = back_en & ~mid_empty;

    opatan_div #(
        .OPERAND_WIDTH       (OPERAND_WIDTH),
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (mid_pop),
        .i_x     (mid_x),
        .i_y     (mid_y),
        .i_class (mid_class),
        .o_valid (div_valid),
        .o_t     (div_t),
        .o_oct   (div_oct)
    );

    opatan_poly #(
        .RATIO_FRACTION_BITS (RATIO_FRACTION_BITS)
    ) u_poly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (back_en),
        .i_valid (div_valid),
        .i_t     (div_t),
        .i_oct   (div_oct),
        .o_valid (poly_valid),
        .o_angle (poly_angle)
    );

    // result queue, head drives the result port
    assign out_push = back_en & poly_valid;

    opatan_fifo #(
        .WIDTH (opatan_pkg::ANGLE_WIDTH),
        .DEPTH (opatan_pkg::QUEUE_DEPTH)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (poly_angle),
        .i_pop   (pop),
        .o_data  (out_data),
        .o_empty (empty),
        .o_full  (out_full)
    );

    assign o_angle = $signed(out_data);

`ifndef SYNTH
    a_angle_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> ((o_angle >= -18000) && (o_angle <= 18000)))
        else $error("angle out of range");
`endif

endmodule

### design/opatan_fifo.sv
`timescale 1ns / 1ps

module opatan_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = opatan_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty,
    output logic             o_full
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd, n_wr, n_rd;
    logic [CW-1:0]    r_count, n_count;
    logic             push_ok, pop_ok;

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(DEPTH));
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push & ~o_full;
    assign pop_ok  = i_pop & ~o_empty;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (push_ok) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        end
        if (pop_ok) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        end
        case ({push_ok, pop_ok})
            2'b10:   n_count = r_count + CW'(1);
            2'b01:   n_count = r_count - CW'(1);
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into full queue");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule

### design/opatan_front.sv
`timescale 1ns / 1ps

module opatan_front #(
    parameter int OPERAND_WIDTH = opatan_pkg::OPERAND_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [OPERAND_WIDTH-1:0] i_y,
    input  logic signed [OPERAND_WIDTH-1:0] i_x,
    output logic                            o_valid,
    output logic signed [OPERAND_WIDTH+1:0] o_x,
    output logic signed [OPERAND_WIDTH+1:0] o_y,
    output opatan_pkg::t_class              o_class
);

    localparam int VW = OPERAND_WIDTH + 2;
    localparam int EW = 3;
    localparam logic signed [EW-1:0] EPS_PLUS  = EW'(1);
    localparam logic signed [EW-1:0] EPS_MINUS = -EW'(1);

    // half-plane and quadrant step
    logic signed [VW-1:0] y0, x0, x1, y1;
    logic signed [EW-1:0] ex1;
    logic                 neg, rot;
    logic signed [VW-1:0] n_xa, n_ya, r_xa, r_ya;
    logic signed [EW-1:0] n_exa, n_eya, r_exa, r_eya;
    opatan_pkg::t_oct     n_octa, r_octa;
    logic                 r_v1;

    // fold step
    logic                 fold;
    logic signed [VW-1:0] n_x, n_y, r_x, r_y;
    opatan_pkg::t_class   n_class, r_class;
    logic                 r_v2;

    assign y0  = VW'(i_y);
    assign x0  = VW'(i_x);
    assign neg = i_y[OPERAND_WIDTH-1];
    assign rot = i_y[OPERAND_WIDTH-1] ^ i_x[OPERAND_WIDTH-1];
    assign x1  = neg ? -x0 : x0;
    assign y1  = neg ? -y0 : y0;
    assign ex1 = (i_x == '0) ? (neg ? EPS_MINUS : EPS_PLUS) : '0;

    always_comb begin
        n_xa   = rot ? y1 : x1;
        n_exa  = rot ? '0 : ex1;
        n_ya   = rot ? -x1 : y1;
        n_eya  = rot ? -ex1 : '0;
        n_octa = {neg, rot, 1'b0};
    end

    always_comb begin
        fold = (r_xa < r_ya) || ((r_xa == r_ya) && (r_exa <= r_eya));
        n_x  = fold ? r_xa + r_ya : r_xa;
        n_y  = fold ? r_ya - r_xa : r_ya;
        n_class.ratio_zero = n_x[VW-1] || (n_x == '0) || n_y[VW-1] || (n_y == '0);
        n_class.oct        = {r_octa[2:1], fold};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xa    <= n_xa;
            r_ya    <= n_ya;
            r_exa   <= n_exa;
            r_eya   <= n_eya;
            r_octa  <= n_octa;
            r_x     <= n_x;
            r_y     <= n_y;
            r_class <= n_class;
        end
    end

    assign o_valid = r_v2;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_class = r_class;

`ifndef SYNTH
    a_ratio_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && !r_class.ratio_zero) |-> (r_y <= r_x))
        else $error("reduced ratio above one");
`endif

endmodule

### design/opatan_div.sv
`timescale 1ns / 1ps

module opatan_div #(
    parameter int OPERAND_WIDTH       = opatan_pkg::OPERAND_WIDTH_DEF,
    parameter int RATIO_FRACTION_BITS = opatan_pkg::RATIO_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_en,
    input  logic                              i_valid,
    input  logic signed [OPERAND_WIDTH+1:0]   i_x,
    input  logic signed [OPERAND_WIDTH+1:0]   i_y,
    input  opatan_pkg::t_class                i_class,
    output logic                              o_valid,
    output logic [RATIO_FRACTION_BITS:0]      o_t,
    output opatan_pkg::t_oct                  o_oct
);

    localparam int VW = OPERAND_WIDTH + 2;
    localparam int QW = RATIO_FRACTION_BITS + 1;
    localparam int NS = RATIO_FRACTION_BITS + 2;

    logic [VW-1:0]      r_rem [NS];
    logic [VW-1:0]      r_dvs [NS];
    logic [QW-1:0]      r_q   [NS];
    opatan_pkg::t_class r_cls [NS];
    logic [NS-1:0]      r_vld;

    logic [QW:0]        q_inc;
    logic [QW-1:0]      n_t, r_t;
    opatan_pkg::t_oct   r_toct;
    logic               r_tv;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= $unsigned(i_y);
            r_dvs[0] <= $unsigned(i_x);
            r_q[0]   <= '0;
            r_cls[0] <= i_class;
        end
    end

    // one quotient bit per stage
    for (genvar k = 1; k < NS; k++) begin : g_step
        logic [VW-1:0] sh, n_rem;
        logic          ge;

        always_comb begin
            sh    = {r_rem[k-1][VW-2:0], 1'b0};
            ge    = (sh >= r_dvs[k-1]);
            n_rem = ge ? sh - r_dvs[k-1] : sh;
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k] <= n_rem;
                r_dvs[k] <= r_dvs[k-1];
                r_q[k]   <= {r_q[k-1][QW-2:0], ge};
                r_cls[k] <= r_cls[k-1];
            end
        end
    end

    // one extra fraction bit, rounded half up
    always_comb begin
        q_inc = {1'b0, r_q[NS-1]} + (QW + 1)'(1);
        n_t   = r_cls[NS-1].ratio_zero ? '0 : q_inc[QW:1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_tv  <= 1'b0;
        end else if (i_en) begin
            r_vld <= {r_vld[NS-2:0], i_valid};
            r_tv  <= r_vld[NS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_t    <= n_t;
            r_toct <= r_cls[NS-1].oct;
        end
    end

    assign o_valid = r_tv;
    assign o_t     = r_t;
    assign o_oct   = r_toct;

`ifndef SYNTH
    a_ratio_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tv |-> (r_t <= (QW'(1) << RATIO_FRACTION_BITS)))
        else $error("ratio above one");
`endif

endmodule

### design/opatan_poly.sv
`timescale 1ns / 1ps

module opatan_poly #(
    parameter int RATIO_FRACTION_BITS = opatan_pkg::RATIO_FRAC_DEF
) (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_en,
    input  logic                                       i_valid,
    input  logic [RATIO_FRACTION_BITS:0]               i_t,
    input  opatan_pkg::t_oct                           i_oct,
    output logic                                       o_valid,
    output logic signed [opatan_pkg::ANGLE_WIDTH-1:0]  o_angle
);

    localparam int AW = opatan_pkg::ACC_WIDTH;
    localparam int SW = opatan_pkg::SUM_WIDTH;
    localparam int TW = RATIO_FRACTION_BITS + 1;
    localparam int PW = AW + TW + 1;
    localparam logic signed [PW-1:0] HALF = PW'(1) << (RATIO_FRACTION_BITS - 1);

    // shift right by the fraction width, ties away from zero
    function automatic logic signed [AW-1:0] round_shift(input logic signed [PW-1:0] a);
        logic signed [PW-1:0] biased;
        biased = a + HALF - {{(PW-1){1'b0}}, a[PW-1]};
        return AW'(biased >>> RATIO_FRACTION_BITS);
    endfunction

    logic [6:0]              r_vld;
    opatan_pkg::t_oct        r_oct [6];
    logic [TW-1:0]           r_tt  [4];
    logic signed [PW-1:0]    n_p1, n_p2, n_p3, r_p1, r_p2, r_p3;
    logic signed [AW-1:0]    n_a2, n_a3, r_a2, r_a3, p_r;
    logic [AW-1:0]           p_c, p_sum;
    logic [SW-1:0]           n_res, r_res;
    logic signed [SW-1:0]    n_sum, n_wrap;
    logic signed [opatan_pkg::ANGLE_WIDTH-1:0] r_ang;

    always_comb begin
        n_p1   = PW'(opatan_pkg::COEF_3) * PW'($signed({1'b0, i_t}));
        n_a2   = opatan_pkg::COEF_2 + round_shift(r_p1);
        n_p2   = PW'(r_a2) * PW'($signed({1'b0, r_tt[1]}));
        n_a3   = opatan_pkg::COEF_1 + round_shift(r_p2);
        n_p3   = PW'(r_a3) * PW'($signed({1'b0, r_tt[3]}));
        p_r    = round_shift(r_p3);
        p_c    = p_r[AW-1] ? '0 : $unsigned(p_r);
        p_sum  = p_c + AW'(opatan_pkg::RES_ROUND);
        n_res  = SW'(p_sum >> opatan_pkg::RES_SHIFT);
        n_sum  = opatan_pkg::octant_base(r_oct[5]) + $signed(r_res);
        n_wrap = (n_sum > opatan_pkg::HALF_TURN) ? n_sum - SW'(opatan_pkg::FULL_TURN) : n_sum;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[5:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_oct[0] <= i_oct;
            for (int s = 1; s < 6; s++) begin
                r_oct[s] <= r_oct[s-1];
            end
            r_tt[0] <= i_t;
            for (int s = 1; s < 4; s++) begin
                r_tt[s] <= r_tt[s-1];
            end
            r_p1  <= n_p1;
            r_a2  <= n_a2;
            r_p2  <= n_p2;
            r_a3  <= n_a3;
            r_p3  <= n_p3;
            r_res <= n_res;
            r_ang <= opatan_pkg::ANGLE_WIDTH'(n_wrap);
        end
    end

    assign o_valid = r_vld[6];
    assign o_angle = r_ang;

endmodule
